// ===== hdl/ledm_pkg.sv =====
// Shared types, constants and lookup tables for the LED matrix frame driver.
// No dependencies; used by led_matrix_digit_frame_driver.
package ledm_pkg;

  localparam int unsigned PIXEL_COUNT = 25;
  localparam int unsigned IDX_W       = $clog2(PIXEL_COUNT);
  localparam logic [7:0]  GLYPH_BLUE  = 8'd200;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_DIGIT   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // Glyph rows for digits 0 to 9; bit 4 is column 0.
  localparam logic [4:0] GLYPH [10][5] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F},
    '{5'h11, 5'h11, 5'h1F, 5'h01, 5'h01},
    '{5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F},
    '{5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08},
    '{5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F}
  };

  // Row and column of each pixel along the serpentine chain.
  function automatic pos_t pixel_pos(logic [IDX_W-1:0] p);
    pos_t pos;
    case (p)
      5'd0:  pos = '{3'd4, 3'd4};  5'd1:  pos = '{3'd4, 3'd3};
      5'd2:  pos = '{3'd4, 3'd2};  5'd3:  pos = '{3'd4, 3'd1};
      5'd4:  pos = '{3'd4, 3'd0};  5'd5:  pos = '{3'd3, 3'd0};
      5'd6:  pos = '{3'd3, 3'd1};  5'd7:  pos = '{3'd3, 3'd2};
      5'd8:  pos = '{3'd3, 3'd3};  5'd9:  pos = '{3'd3, 3'd4};
      5'd10: pos = '{3'd2, 3'd4};  5'd11: pos = '{3'd2, 3'd3};
      5'd12: pos = '{3'd2, 3'd2};  5'd13: pos = '{3'd2, 3'd1};
      5'd14: pos = '{3'd2, 3'd0};  5'd15: pos = '{3'd1, 3'd0};
      5'd16: pos = '{3'd1, 3'd1};  5'd17: pos = '{3'd1, 3'd2};
      5'd18: pos = '{3'd1, 3'd3};  5'd19: pos = '{3'd1, 3'd4};
      5'd20: pos = '{3'd0, 3'd4};  5'd21: pos = '{3'd0, 3'd3};
      5'd22: pos = '{3'd0, 3'd2};  5'd23: pos = '{3'd0, 3'd1};
      5'd24: pos = '{3'd0, 3'd0};
      default: pos = '{3'd0, 3'd0};
    endcase
    return pos;
  endfunction

  // True when pixel p is lit in the glyph of digit d (d must be 0 to 9).
  function automatic logic glyph_lit(logic [3:0] d, logic [IDX_W-1:0] p);
    pos_t       pos;
    logic [4:0] bits;
    pos  = pixel_pos(p);
    bits = GLYPH[d][pos.row];
    return bits[3'd4 - pos.col];
  endfunction

endpackage

// ===== hdl/ledm_scaler.sv =====
// Shared 8x8 multiplier with a divide-by-255 fold on the registered product.
// Uses no package; instantiated by led_matrix_digit_frame_driver.
module ledm_scaler (
  input  logic       clk,
  input  logic [7:0] level_i,
  input  logic [7:0] factor_i,
  output logic [7:0] quot_o
);

  logic [15:0] prod_r;
  logic [16:0] fold;

  always_ff @(posedge clk) begin
    prod_r <= level_i * factor_i;
  end

  // floor(x/255) for any product x of two 8-bit values is (x + (x >> 8) + 1) >> 8.
  assign fold   = {1'b0, prod_r} + {9'd0, prod_r[15:8]} + 17'd1;
  assign quot_o = fold[15:8];

endmodule

// ===== hdl/led_matrix_digit_frame_driver.sv =====
// Top level of the 5x5 LED matrix frame driver: frame store, sequencer and output register.
// Depends on ledm_pkg and ledm_scaler.
//
// A set-pixel word is taken while the sequencer is idle, then runs four steps through the single
// shared multiplier and its divide-by-255 fold. Red, green and blue pass through that
// pipeline one behind another, and the last step writes the pixel. A set-pixel word with an
// index above 24 is dropped when it is taken. Clear and refresh emit 25 pixel words, and
// show-digit emits 50 (25 when the digit is above 9). The output register sends one pixel
// word per cycle while out_ready is high. The input is accepted only while the sequencer is
// idle.
module led_matrix_digit_frame_driver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [4:0] in_pixel_index,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_brightness,
  input  logic [3:0] in_digit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_green_out,
  output logic [7:0] out_red_out,
  output logic [7:0] out_blue_out,
  output logic       out_frame_last
);

  localparam int unsigned N = ledm_pkg::PIXEL_COUNT;
  localparam int unsigned W = ledm_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_EMIT_STORE,
    S_EMIT_GLYPH
  } state_t;

  state_t         state_r, state_nxt;
  logic [W-1:0]   pix_r, pix_nxt;
  logic [W-1:0]   idx_r, idx_nxt;
  logic [1:0]     step_r, step_nxt;
  logic [7:0]     red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [7:0]     bright_r, bright_nxt;
  logic [3:0]     digit_r, digit_nxt;
  logic           pend_r, pend_nxt;
  logic [7:0]     red_q_r, red_q_nxt, green_q_r, green_q_nxt;
  logic [N-1:0]   valid_r, valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_green_r, out_green_nxt, out_red_r, out_red_nxt;
  logic [7:0]     out_blue_r, out_blue_nxt;
  logic           out_last_r, out_last_nxt;

  logic [23:0]    store_r [N];
  logic           store_we;
  logic [W-1:0]   store_addr;
  logic [23:0]    store_wdata;

  logic [7:0]     scale_level;
  logic [7:0]     scale_quot;
  logic           can_load;
  logic           last_pix;
  logic           lit;
  logic [23:0]    pix_color;

  ledm_scaler u_scaler (
    .clk      (clk),
    .level_i  (scale_level),
    .factor_i (bright_r),
    .quot_o   (scale_quot)
  );

  always_comb begin
    case (step_r)
      2'd0:    scale_level = red_r;
      2'd1:    scale_level = green_r;
      default: scale_level = blue_r;
    endcase
  end

  assign can_load = !out_valid_r || out_ready;
  assign last_pix = (pix_r == W'(N - 1));
  assign lit      = ledm_pkg::glyph_lit(digit_r, pix_r);

  always_comb begin
    if (state_r == S_EMIT_GLYPH) begin
      pix_color = lit ? {16'd0, ledm_pkg::GLYPH_BLUE} : 24'd0;
    end else begin
      pix_color = valid_r[pix_r] ? store_r[pix_r] : 24'd0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pix_nxt       = pix_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    bright_nxt    = bright_r;
    digit_nxt     = digit_r;
    pend_nxt      = pend_r;
    red_q_nxt     = red_q_r;
    green_q_nxt   = green_q_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_green_nxt = out_green_r;
    out_red_nxt   = out_red_r;
    out_blue_nxt  = out_blue_r;
    out_last_nxt  = out_last_r;
    store_we      = 1'b0;
    store_addr    = pix_r;
    store_wdata   = {16'd0, ledm_pkg::GLYPH_BLUE};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt    = in_pixel_index;
          red_nxt    = in_red_in;
          green_nxt  = in_green_in;
          blue_nxt   = in_blue_in;
          bright_nxt = in_brightness;
          digit_nxt  = in_digit;
          pix_nxt    = '0;
          step_nxt   = '0;
          pend_nxt   = 1'b0;
          case (ledm_pkg::op_t'(in_op))
            ledm_pkg::OP_SET: begin
              if (in_pixel_index < W'(N)) begin
                state_nxt = S_SCALE;
              end
            end
            ledm_pkg::OP_CLEAR: begin
              valid_nxt = '0;
              state_nxt = S_EMIT_STORE;
            end
            ledm_pkg::OP_DIGIT: begin
              valid_nxt = '0;
              pend_nxt  = (in_digit <= 4'd9);
              state_nxt = S_EMIT_STORE;
            end
            default: begin
              state_nxt = S_EMIT_STORE;
            end
          endcase
        end
      end
      S_SCALE: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd1: red_q_nxt   = scale_quot;
          2'd2: green_q_nxt = scale_quot;
          2'd3: begin
            store_we          = 1'b1;
            store_addr        = idx_r;
            store_wdata       = {red_q_r, green_q_r, scale_quot};
            valid_nxt[idx_r]  = 1'b1;
            state_nxt         = S_IDLE;
          end
          default: ;
        endcase
      end
      S_EMIT_STORE, S_EMIT_GLYPH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = pix_color[23:16];
          out_green_nxt = pix_color[15:8];
          out_blue_nxt  = pix_color[7:0];
          out_last_nxt  = last_pix;
          if (state_r == S_EMIT_GLYPH) begin
            store_we         = 1'b1;
            valid_nxt[pix_r] = lit;
          end
          if (last_pix) begin
            pix_nxt   = '0;
            state_nxt = (state_r == S_EMIT_STORE && pend_r) ? S_EMIT_GLYPH : S_IDLE;
          end else begin
            pix_nxt = pix_r + W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pix_r       <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_r       <= pix_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    bright_r    <= bright_nxt;
    digit_r     <= digit_nxt;
    red_q_r     <= red_q_nxt;
    green_q_r   <= green_q_nxt;
    out_green_r <= out_green_nxt;
    out_red_r   <= out_red_nxt;
    out_blue_r  <= out_blue_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_addr] <= store_wdata;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_green_out  = out_green_r;
  assign out_red_out    = out_red_r;
  assign out_blue_out   = out_blue_r;
  assign out_frame_last = out_last_r;

  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    pix_r < W'(N))
    else $error("pixel counter out of range");

  a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == ledm_pkg::OP_CLEAR || in_op == ledm_pkg::OP_DIGIT)
    |=> valid_r == '0)
    else $error("clear did not blank the frame store");

  a_glyph_after_blank: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_EMIT_GLYPH) |-> $past(state_r) == S_EMIT_STORE && $past(pend_r))
    else $error("glyph frame not preceded by the blank frame");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_STORE || state_r == S_EMIT_GLYPH) && can_load && last_pix
    |=> out_valid_r && out_last_r)
    else $error("last pixel word not flagged");

endmodule
